### hdl/sc2d_pkg.sv
// Package for the separable 2-D convolution unit: shared constants,
// register index codes and the sequencer state type. No dependencies.
`default_nettype none

package sc2d_pkg;

    localparam int MAX_TAPS_DEF       = 16;
    localparam int MAX_WIDTH_DEF      = 1024;
    localparam int COEF_FRAC_BITS_DEF = 14;

    localparam int MAX_HEIGHT = 4096;
    localparam int COEF_REGS  = 16;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_TAP_COUNT    = 3'd2,
        REG_TAP_OFFSET   = 3'd3,
        REG_COEF_A       = 3'd4,
        REG_COEF_B       = 3'd5,
        REG_COEF_C       = 3'd6,
        REG_COEF_D       = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_VSUM,
        ST_HSUM,
        ST_OUT
    } seq_state_t;

endpackage

`default_nettype wire

### hdl/separable_convolution_2d_unit.sv
// Separable 2-D convolution unit: line memory, vertical and horizontal
// multiply-accumulate sequencer, output register. Depends on sc2d_pkg.
`default_nettype none

// Usage
//   Input channel (s_valid/s_ready, s_sample, s_frame_start): one signed
//   16-bit sample per transaction, image plane in raster order. frame_start
//   puts the sample at row 0, column 0.
//   Result channel (m_valid/m_ready): zero or one result per sample, only
//   for windows wholly inside the plane, at (wx - tap_offset, wy - tap_offset).
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//   write only while the unit is idle.
// Timing
//   One item at a time. The line memory (one word of K-1 samples per
//   column) is read at acceptance and written back on the next cycle.
//   A single 16 x CSUM_W multiplier runs the K vertical taps, then, for an
//   item that gives a result, the K horizontal taps, one tap a cycle.
//   A finished result sits in the output register; the next sample is
//   accepted while it waits and the unit only holds when a second result
//   is ready before the first is taken.
// Reset
//   aresetn clears counters, sequencer, output valid and registers to their
//   defaults. The line memory is not cleared; a full set of rows is written
//   before any window uses it.
module separable_convolution_2d_unit #(
    parameter int MAX_TAPS       = sc2d_pkg::MAX_TAPS_DEF,
    parameter int MAX_WIDTH      = sc2d_pkg::MAX_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = sc2d_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [sc2d_pkg::SAMPLE_W-1:0] s_sample,
    input  wire logic                                s_frame_start,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [15:0]                       m_filtered,
    output logic signed [11:0]                       m_out_x,
    output logic signed [13:0]                       m_out_y,
    output logic                                     m_frame_last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sc2d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sc2d_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LINE_COUNT = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
    localparam int SW         = sc2d_pkg::SAMPLE_W;
    localparam int MW         = LINE_COUNT * SW;
    localparam int AW         = $clog2(MAX_WIDTH);
    localparam int KW         = $clog2(MAX_TAPS + 1);
    localparam int CSUM_W     = 32 + $clog2(MAX_TAPS);
    localparam int PROD_W     = sc2d_pkg::COEF_W + CSUM_W;
    localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS);
    localparam int SH         = 2 * COEF_FRAC_BITS;
    localparam int RW         = sc2d_pkg::ROW_W;

    // configuration registers
    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [4:0]  tap_count_reg;
    logic [5:0]  tap_offset_reg;
    logic [4*sc2d_pkg::CFG_DATA_W-1:0] coef_reg;

    // position counters
    logic [AW-1:0] cnt_col_reg;
    logic [RW-1:0] cnt_row_reg;

    // item in flight
    logic signed [SW-1:0] s_reg;
    logic [AW-1:0]        c_reg;
    logic [RW-1:0]        r_reg;

    // sequencer
    sc2d_pkg::seq_state_t state_reg, state_next;
    logic [KW-1:0]            j_reg;
    logic                     pv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [CSUM_W-1:0] csum_reg [MAX_TAPS];

    // line memory
    logic [MW-1:0] line_mem [MAX_WIDTH];
    logic [MW-1:0] line_q_reg;
    logic [MW-1:0] line_wdata;
    logic [AW-1:0] rd_addr;
    logic          mem_re;
    logic          mem_we;

    // output register
    logic              m_valid_reg;
    logic signed [15:0] m_filtered_reg;
    logic signed [11:0] m_out_x_reg;
    logic signed [13:0] m_out_y_reg;
    logic              m_frame_last_reg;

    logic [31:0] w_eff, h_eff, k_eff;
    logic        accept;
    logic [AW-1:0] c_in;
    logic [RW-1:0] r_in;
    logic        last_tap_done;
    logic        emit;
    logic        out_free;

    logic signed [sc2d_pkg::COEF_W-1:0] mul_a;
    logic signed [CSUM_W-1:0]           mul_b;
    logic signed [SW-1:0]               line_sel;
    logic signed [CSUM_W-1:0]           csum_sel;
    logic signed [ACC_W-1:0]            rnd;
    logic signed [ACC_W-1:0]            shifted;
    logic signed [15:0]                 sat;
    logic signed [15:0]                 ox_full, oy_full;
    logic [KW-1:0]                      line_idx, csum_idx;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == sc2d_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;

    // effective, clamped configuration
    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = 32'd1;
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = 32'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_eff = 32'd1;
        end else if (32'(image_height_reg) > 32'(sc2d_pkg::MAX_HEIGHT)) begin
            h_eff = 32'(sc2d_pkg::MAX_HEIGHT);
        end else begin
            h_eff = 32'(image_height_reg);
        end
        if (tap_count_reg == '0) begin
            k_eff = 32'd1;
        end else if (32'(tap_count_reg) > 32'(MAX_TAPS)) begin
            k_eff = 32'(MAX_TAPS);
        end else begin
            k_eff = 32'(tap_count_reg);
        end
    end

    // position of the incoming sample
    assign c_in    = s_frame_start ? '0 : cnt_col_reg;
    assign r_in    = s_frame_start ? '0 : cnt_row_reg;
    assign rd_addr = c_in;
    assign mem_re  = accept;

    // write back the shifted column on the first cycle of the vertical pass
    assign mem_we     = (state_reg == sc2d_pkg::ST_VSUM) && (j_reg == '0) && !pv_reg;
    assign line_wdata = (line_q_reg << SW) | MW'($unsigned(s_reg));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[c_reg] <= line_wdata;
        end
        if (mem_re) begin
            line_q_reg <= line_mem[rd_addr];
        end
    end

    // operand selection for the shared multiplier
    assign line_idx = KW'(k_eff - 32'd2 - 32'(j_reg));
    assign csum_idx = KW'(k_eff - 32'd1 - 32'(j_reg));

    always_comb begin
        mul_a = '0;
        for (int i = 0; i < sc2d_pkg::COEF_REGS; i++) begin
            if (32'(j_reg) == i) begin
                mul_a = coef_reg[i*sc2d_pkg::COEF_W +: sc2d_pkg::COEF_W];
            end
        end
        line_sel = '0;
        for (int l = 0; l < LINE_COUNT; l++) begin
            if (32'(line_idx) == l) begin
                line_sel = line_q_reg[l*SW +: SW];
            end
        end
        csum_sel = '0;
        for (int t = 0; t < MAX_TAPS; t++) begin
            if (32'(csum_idx) == t) begin
                csum_sel = csum_reg[t];
            end
        end
        if (state_reg == sc2d_pkg::ST_HSUM) begin
            mul_b = csum_sel;
        end else if (32'(j_reg) + 32'd1 == k_eff) begin
            mul_b = CSUM_W'(s_reg);
        end else begin
            mul_b = CSUM_W'(line_sel);
        end
    end

    assign last_tap_done = (32'(j_reg) == k_eff) && !pv_reg;
    assign emit = (32'(c_reg) + 32'd1 >= k_eff) && (32'(r_reg) + 32'd1 >= k_eff)
               && (32'(c_reg) < w_eff) && (32'(r_reg) < h_eff);
    assign out_free = !m_valid_reg || m_ready;

    // round, shift and saturate the result; compute the output coordinates
    always_comb begin
        rnd     = acc_reg + (ACC_W'(64'sd1) <<< (SH - 1));
        shifted = rnd >>> SH;
        if (shifted > ACC_W'(32'sd32767)) begin
            sat = 16'sh7fff;
        end else if (shifted < ACC_W'(-32'sd32768)) begin
            sat = -16'sh8000;
        end else begin
            sat = shifted[15:0];
        end
        ox_full = 16'(signed'({1'b0, c_reg})) - 16'(k_eff) + 16'sd1
                - 16'(signed'(tap_offset_reg));
        oy_full = 16'(signed'({1'b0, r_reg})) - 16'(k_eff) + 16'sd1
                - 16'(signed'(tap_offset_reg));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sc2d_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = sc2d_pkg::ST_VSUM;
                end
            end
            sc2d_pkg::ST_VSUM: begin
                if (last_tap_done) begin
                    state_next = emit ? sc2d_pkg::ST_HSUM : sc2d_pkg::ST_IDLE;
                end
            end
            sc2d_pkg::ST_HSUM: begin
                if (last_tap_done) begin
                    state_next = sc2d_pkg::ST_OUT;
                end
            end
            sc2d_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = sc2d_pkg::ST_IDLE;
                end
            end
            default: state_next = sc2d_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sc2d_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 11'd1024;
            image_height_reg <= 13'd1024;
            tap_count_reg    <= 5'd1;
            tap_offset_reg   <= '0;
            coef_reg         <= {192'd0, 64'd16384};
        end else if (cfg_valid && cfg_ready) begin
            case (sc2d_pkg::cfg_reg_t'(cfg_index))
                sc2d_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                sc2d_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[12:0];
                sc2d_pkg::REG_TAP_COUNT:    tap_count_reg    <= cfg_data[4:0];
                sc2d_pkg::REG_TAP_OFFSET:   tap_offset_reg   <= cfg_data[5:0];
                sc2d_pkg::REG_COEF_A:       coef_reg[63:0]    <= cfg_data;
                sc2d_pkg::REG_COEF_B:       coef_reg[127:64]  <= cfg_data;
                sc2d_pkg::REG_COEF_C:       coef_reg[191:128] <= cfg_data;
                sc2d_pkg::REG_COEF_D:       coef_reg[255:192] <= cfg_data;
                default: ;
            endcase
        end
    end

    // position counters: advance on every accepted sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_col_reg <= '0;
            cnt_row_reg <= '0;
        end else if (accept) begin
            if (32'(c_in) + 32'd1 >= w_eff) begin
                cnt_col_reg <= '0;
                cnt_row_reg <= (32'(r_in) + 32'd1 >= h_eff) ? '0 : r_in + RW'(1);
            end else begin
                cnt_col_reg <= c_in + AW'(1);
                cnt_row_reg <= r_in;
            end
        end
    end

    // datapath: tap counter, product register, accumulator, column sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg  <= '0;
            pv_reg <= 1'b0;
        end else begin
            case (state_reg)
                sc2d_pkg::ST_IDLE: begin
                    j_reg  <= '0;
                    pv_reg <= 1'b0;
                end
                sc2d_pkg::ST_VSUM, sc2d_pkg::ST_HSUM: begin
                    if (last_tap_done) begin
                        j_reg  <= '0;
                        pv_reg <= 1'b0;
                    end else if (32'(j_reg) < k_eff) begin
                        j_reg  <= j_reg + KW'(1);
                        pv_reg <= 1'b1;
                    end else begin
                        pv_reg <= 1'b0;
                    end
                end
                default: begin
                    pv_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s_reg   <= s_sample;
            c_reg   <= c_in;
            r_reg   <= r_in;
            acc_reg <= '0;
        end else if (state_reg == sc2d_pkg::ST_VSUM && last_tap_done) begin
            // shift the finished vertical sum into the column row
            for (int t = MAX_TAPS - 1; t >= 1; t--) begin
                csum_reg[t] <= csum_reg[t-1];
            end
            csum_reg[0] <= acc_reg[CSUM_W-1:0];
            acc_reg     <= '0;
        end else if (pv_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        prod_reg <= mul_a * mul_b;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == sc2d_pkg::ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == sc2d_pkg::ST_OUT && out_free) begin
            m_filtered_reg   <= sat;
            m_out_x_reg      <= ox_full[11:0];
            m_out_y_reg      <= oy_full[13:0];
            m_frame_last_reg <= (32'(c_reg) + 32'd1 == w_eff)
                             && (32'(r_reg) + 32'd1 == h_eff);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_filtered   = m_filtered_reg;
    assign m_out_x      = m_out_x_reg;
    assign m_out_y      = m_out_y_reg;
    assign m_frame_last = m_frame_last_reg;

`ifndef SYNTHESIS
    a_accept_starts_vsum: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == sc2d_pkg::ST_VSUM)
        else $error("accepted sample did not start the vertical pass");

    a_tap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sc2d_pkg::ST_VSUM || state_reg == sc2d_pkg::ST_HSUM)
        |-> 32'(j_reg) <= k_eff)
        else $error("tap counter ran past the tap count");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == sc2d_pkg::ST_OUT)
        else $error("result raised outside the output state");

    a_write_once: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> !mem_we)
        else $error("line memory written twice for one sample");
`endif

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for separable_convolution_2d_unit: directed table, then
// random image planes checked against an in-bench filter predictor.
// Depends on sc2d_pkg and the unit's RTL only.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAP_MAX     = 16;
    localparam int LINE_MAX    = 1024;
    localparam int LINE_DEPTH  = TAP_MAX - 1;
    localparam int FRAC2       = 2 * sc2d_pkg::COEF_FRAC_BITS_DEF;
    // drain allowance for a sample still in flight after the last result, padded
    localparam int DRAIN_CYC   = 2 * TAP_MAX + 12;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_ITEMS  = 880;
    localparam int QUIET_AFTER = 760;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic [11:0]        out_x;
        logic [13:0]        out_y;
        logic               frame_last;
    } pixel_out_t;

    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} chk_mode_t;
    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        sc2d_pkg::cfg_reg_t idx;
        logic [63:0]        data;
        logic [15:0]        sample;
        logic               fs;
        chk_mode_t          mode;
        pixel_out_t         exp_px;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample = '0;
    logic               s_frame_start = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_filtered;
    logic signed [11:0] m_out_x;
    logic signed [13:0] m_out_y;
    logic               m_frame_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    sc2d_pkg::cfg_reg_t cfg_index = sc2d_pkg::REG_IMAGE_WIDTH;
    logic [63:0]        cfg_data = '0;

    separable_convolution_2d_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample(s_sample), .s_frame_start(s_frame_start),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_filtered(m_filtered), .m_out_x(m_out_x), .m_out_y(m_out_y),
        .m_frame_last(m_frame_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------------------------
    // Filter predictor: private copy of registers, line memory and column sums
    // ---------------------------------------------------------------------------------
    logic [10:0]        pr_width  = 11'd1024;
    logic [12:0]        pr_height = 13'd1024;
    logic [4:0]         pr_taps   = 5'd1;
    logic signed [5:0]  pr_off    = '0;
    logic [63:0]        pr_coef [4] = '{64'd16384, 64'd0, 64'd0, 64'd0};
    logic signed [15:0] line_mem [LINE_DEPTH][LINE_MAX];
    longint             col_sum [TAP_MAX];
    int                 col_cnt = 0;
    int                 row_cnt = 0;

    pixel_out_t         pending_px[$];
    int                 err_cnt = 0;
    bit                 quiet = 1'b0;
    bit                 hold_req = 1'b0;
    int                 rx_stall = 0;
    int                 idle_cyc = 0;

    initial begin
        for (int l = 0; l < LINE_DEPTH; l++)
            for (int x = 0; x < LINE_MAX; x++)
                line_mem[l][x] = '0;
        for (int j = 0; j < TAP_MAX; j++)
            col_sum[j] = 0;
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint tap_coef(int i);
        logic [15:0] hw;
        hw = pr_coef[i / 4][16 * (i % 4) +: 16];
        return longint'($signed(hw));
    endfunction

    function automatic void apply_reg(sc2d_pkg::cfg_reg_t idx, logic [63:0] val);
        case (idx)
            sc2d_pkg::REG_IMAGE_WIDTH:  pr_width  = val[10:0];
            sc2d_pkg::REG_IMAGE_HEIGHT: pr_height = val[12:0];
            sc2d_pkg::REG_TAP_COUNT:    pr_taps   = val[4:0];
            sc2d_pkg::REG_TAP_OFFSET:   pr_off    = val[5:0];
            sc2d_pkg::REG_COEF_A:       pr_coef[0] = val;
            sc2d_pkg::REG_COEF_B:       pr_coef[1] = val;
            sc2d_pkg::REG_COEF_C:       pr_coef[2] = val;
            default:                    pr_coef[3] = val;
        endcase
    endfunction

    // Advance the filter by one sample; returns 1 when a window completes.
    function automatic bit filter_step(logic signed [15:0] smp, logic fs,
                                       output pixel_out_t px);
        int     w, h, k, c, r, col, wx, wy;
        longint vs, acc, res;
        bit     hit;
        w = clamp(int'(pr_width), 1, LINE_MAX);
        h = clamp(int'(pr_height), 1, sc2d_pkg::MAX_HEIGHT);
        k = clamp(int'(pr_taps), 1, TAP_MAX);
        c = fs ? 0 : col_cnt;
        r = fs ? 0 : row_cnt;
        col = c % LINE_MAX;
        px = '0;
        hit = 1'b0;

        // vertical pass: newest sample takes the last tap
        vs = tap_coef(k - 1) * longint'(smp);
        for (int i = 0; i + 1 < k; i++)
            vs += tap_coef(k - 2 - i) * longint'(line_mem[i][col]);
        for (int l = LINE_DEPTH - 1; l >= 1; l--)
            line_mem[l][col] = line_mem[l - 1][col];
        line_mem[0][col] = smp;
        for (int j = TAP_MAX - 1; j >= 1; j--)
            col_sum[j] = col_sum[j - 1];
        col_sum[0] = vs;

        if (c + 1 >= k && r + 1 >= k && c < w && r < h) begin
            acc = 0;
            for (int i = 0; i < k; i++)
                acc += tap_coef(i) * col_sum[k - 1 - i];
            acc += longint'(1) <<< (FRAC2 - 1);
            res = acc >>> FRAC2;
            if (res > 32767) res = 32767;
            if (res < -32768) res = -32768;
            wx = c - (k - 1) - int'(pr_off);
            wy = r - (k - 1) - int'(pr_off);
            px.filtered   = res[15:0];
            px.out_x      = wx[11:0];
            px.out_y      = wy[13:0];
            px.frame_last = (c + 1 == w && r + 1 == h);
            hit = 1'b1;
        end

        if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            c++;
        end
        col_cnt = c;
        row_cnt = r;
        return hit;
    endfunction

    // ---------------------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------------------
    // Offer one sample and hold it until accepted; valid stays high afterwards so the
    // next sample can follow back to back.
    task automatic send_sample(logic [15:0] smp, logic fs, chk_mode_t mode,
                               pixel_out_t typed);
        pixel_out_t px;
        bit         hit;
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        hit = filter_step(smp, fs, px);
        if (mode == CHK_MODEL && hit)
            pending_px.push_back(px);
        else if (mode == CHK_VALUE)
            pending_px.push_back(typed);
    endtask

    task automatic sender_gap(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 5) == 0)
            sender_gap($urandom_range(1, 8));
    endtask

    // Write one register, then lower valid and idle with valid low before returning, so
    // that consecutive writes never stack two assignments in one step.
    task automatic write_reg(sc2d_pkg::cfg_reg_t idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the sender until every result is in, then let the pipeline settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic program_plane(int wf, int hf, int kf, logic [63:0] cf [4]);
        write_reg(sc2d_pkg::REG_IMAGE_WIDTH, 64'(wf));
        write_reg(sc2d_pkg::REG_IMAGE_HEIGHT, 64'(hf));
        write_reg(sc2d_pkg::REG_TAP_COUNT, 64'(kf));
        write_reg(sc2d_pkg::REG_TAP_OFFSET, 64'($urandom_range(0, 63)));
        write_reg(sc2d_pkg::REG_COEF_A, cf[0]);
        write_reg(sc2d_pkg::REG_COEF_B, cf[1]);
        write_reg(sc2d_pkg::REG_COEF_C, cf[2]);
        write_reg(sc2d_pkg::REG_COEF_D, cf[3]);
    endtask

    function automatic logic [15:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'h7FFF;
        if (pick == 1) return 16'h8000;
        return 16'($urandom);
    endfunction

    function automatic logic [63:0] rand_coef(int style);
        logic [63:0] v;
        int          pick;
        v = '0;
        for (int t = 0; t < 4; t++) begin
            case (style)
                0: v[16 * t +: 16] = 16'($urandom);
                1: v[16 * t +: 16] = 16'($urandom_range(0, 4095) - 2048);
                default: begin
                    pick = $urandom_range(0, 2);
                    v[16 * t +: 16] = (pick == 0) ? 16'h7FFF :
                                      (pick == 1) ? 16'h8000 : 16'h0000;
                end
            endcase
        end
        return v;
    endfunction

    // Send one plane of w x h samples; with noise set, a few samples restart the
    // plane mid-stream with a stray frame_start.
    task automatic run_plane(int w, int h, bit noise, inout int sent);
        logic fs;
        for (int n = 0; n < w * h; n++) begin
            if (n == 0)
                fs = !(col_cnt == 0 && row_cnt == 0 && $urandom_range(0, 3) == 0);
            else
                fs = noise && ($urandom_range(0, 29) == 0);
            send_sample(rand_sample(), fs, CHK_MODEL, '0);
            sent++;
            if (sent >= QUIET_AFTER) quiet = 1'b1;
            maybe_gap();
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------------------------
    dir_row_t dir_tab[$];

    function automatic dir_row_t row_s(logic [15:0] smp, logic fs, chk_mode_t mode,
                                       int f, int x, int y, logic last);
        dir_row_t rw;
        rw.kind   = ROW_SAMPLE;
        rw.idx    = sc2d_pkg::REG_IMAGE_WIDTH;
        rw.data   = '0;
        rw.sample = smp;
        rw.fs     = fs;
        rw.mode   = mode;
        rw.exp_px = '{filtered: f[15:0], out_x: x[11:0], out_y: y[13:0],
                      frame_last: last};
        return rw;
    endfunction

    function automatic dir_row_t row_c(sc2d_pkg::cfg_reg_t idx, logic [63:0] val);
        dir_row_t rw;
        rw = row_s('0, 1'b0, CHK_NONE, 0, 0, 0, 1'b0);
        rw.kind = ROW_CFG;
        rw.idx  = idx;
        rw.data = val;
        return rw;
    endfunction

    initial begin
        // reset defaults: one tap of 1.0, so each sample comes straight back
        dir_tab.push_back(row_s(16'h7FFF, 1, CHK_VALUE, 32767, 0, 0, 0));
        dir_tab.push_back(row_s(16'h8000, 0, CHK_VALUE, -32768, 1, 0, 0));
        dir_tab.push_back(row_s(16'h0000, 0, CHK_VALUE, 0, 2, 0, 0));
        dir_tab.push_back(row_s(16'h0001, 0, CHK_VALUE, 1, 3, 0, 0));
        dir_tab.push_back(row_s(16'hFFFF, 0, CHK_VALUE, -1, 4, 0, 0));
        dir_tab.push_back(row_s(16'h5555, 0, CHK_VALUE, 21845, 5, 0, 0));
        dir_tab.push_back(row_s(16'hAAAA, 0, CHK_VALUE, -21846, 6, 0, 0));
        // shrink the width below the current column: the next sample ends the row
        dir_tab.push_back(row_c(sc2d_pkg::REG_IMAGE_WIDTH, 64'd4));
        dir_tab.push_back(row_s(16'd123, 0, CHK_NONE, 0, 0, 0, 0));
        dir_tab.push_back(row_s(16'd77, 0, CHK_VALUE, 77, 0, 1, 0));
        dir_tab.push_back(row_s(16'd5, 0, CHK_VALUE, 5, 1, 1, 0));
        // two rows high: last sample of row one closes the plane
        dir_tab.push_back(row_c(sc2d_pkg::REG_IMAGE_HEIGHT, 64'd2));
        dir_tab.push_back(row_s(16'hFFFB, 0, CHK_VALUE, -5, 2, 1, 0));
        dir_tab.push_back(row_s(16'd9, 0, CHK_VALUE, 9, 3, 1, 1));
        // counters wrapped, so this one starts a plane without frame_start
        dir_tab.push_back(row_s(16'd42, 0, CHK_VALUE, 42, 0, 0, 0));
        // an offset of -16 shifts the output coordinates up by 16
        dir_tab.push_back(row_c(sc2d_pkg::REG_TAP_OFFSET, 64'h30));
        dir_tab.push_back(row_s(16'd1000, 0, CHK_VALUE, 1000, 17, 16, 0));
        // largest coefficient saturates both ways; the most negative one is
        // applied twice, so its gain is positive and the sign of the sample holds
        dir_tab.push_back(row_c(sc2d_pkg::REG_COEF_A, 64'h7FFF));
        dir_tab.push_back(row_s(16'h7FFF, 0, CHK_VALUE, 32767, 18, 16, 0));
        dir_tab.push_back(row_s(16'h8000, 0, CHK_VALUE, -32768, 19, 16, 0));
        dir_tab.push_back(row_c(sc2d_pkg::REG_COEF_A, 64'h8000));
        dir_tab.push_back(row_s(16'h8000, 0, CHK_VALUE, -32768, 16, 17, 0));
        // 3x3 plane with a 3-tap kernel: one window, checked by the predictor
        dir_tab.push_back(row_c(sc2d_pkg::REG_IMAGE_WIDTH, 64'd3));
        dir_tab.push_back(row_c(sc2d_pkg::REG_IMAGE_HEIGHT, 64'd3));
        dir_tab.push_back(row_c(sc2d_pkg::REG_TAP_COUNT, 64'd3));
        dir_tab.push_back(row_c(sc2d_pkg::REG_TAP_OFFSET, 64'd1));
        dir_tab.push_back(row_c(sc2d_pkg::REG_COEF_A, 64'h0000_1000_2000_1000));
        for (int i = 0; i < 9; i++)
            dir_tab.push_back(row_s(16'(i * 3001 - 12000), (i == 0), CHK_MODEL,
                                    0, 0, 0, 0));
    end

    // ---------------------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ---------------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            rx_stall = LONG_HOLD;
        end else if (rx_stall == 0 && !quiet && $urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(1, 8);
        end
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Result checker: compare each result transaction with the oldest expectation
    // ---------------------------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_px.size() == 0) begin
                $display("%0t: unexpected result filtered %0d x %0d y %0d last %0b",
                         $time, m_filtered, m_out_x, m_out_y, m_frame_last);
                err_cnt++;
            end else begin
                want = pending_px.pop_front();
                if (m_filtered !== want.filtered) begin
                    $display("%0t: filtered expected %0d actual %0d",
                             $time, want.filtered, m_filtered);
                    err_cnt++;
                end
                if (m_out_x !== want.out_x) begin
                    $display("%0t: out_x expected %0d actual %0d",
                             $time, $signed(want.out_x), m_out_x);
                    err_cnt++;
                end
                if (m_out_y !== want.out_y) begin
                    $display("%0t: out_y expected %0d actual %0d",
                             $time, $signed(want.out_y), m_out_y);
                    err_cnt++;
                end
                if (m_frame_last !== want.frame_last) begin
                    $display("%0t: frame_last expected %0b actual %0b",
                             $time, want.frame_last, m_frame_last);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= STALL_LIMIT) begin
            $display("separable_convolution_2d_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial begin
        int          sent;
        int          plane;
        int          k, kf, w, h;
        logic [63:0] cf [4];
        int          style;

        sent  = 0;
        plane = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table; registers only change once the unit is idle
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                drain();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_sample(dir_tab[i].sample, dir_tab[i].fs, dir_tab[i].mode,
                            dir_tab[i].exp_px);
                maybe_gap();
            end
        end

        // clamped registers: lowest values give one-sample planes, highest ones
        // a wide, tall plane of which a part of the first row is sent
        drain();
        cf = '{64'h4000, 64'h0, 64'h0, 64'h0};
        program_plane(0, 0, 0, cf);
        run_plane(1, 3, 1'b0, sent);
        drain();
        program_plane(2047, 8191, 1, cf);
        run_plane(40, 1, 1'b0, sent);
        drain();
        for (int t = 0; t < 4; t++) cf[t] = rand_coef(1);
        program_plane(16, 16, 16, cf);
        run_plane(16, 16, 1'b0, sent);
        drain();
        for (int t = 0; t < 4; t++) cf[t] = rand_coef(2);
        program_plane(17, 17, 31, cf);
        run_plane(17, 17, 1'b0, sent);

        while (sent < RAND_ITEMS) begin
            drain();
            if (plane == 1) begin
                // every sample past the first row and column gives a result: hold the
                // receiver off so the unit fills up and stalls its input
                k = 2;
                kf = 2;
                w = 10;
                h = 10;
                hold_req = 1'b1;
            end else begin
                k = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 16);
                kf = (k == 1 && $urandom_range(0, 3) == 0) ? 0 : k;
                w = k + $urandom_range(0, 5);
                if (k > 1 && $urandom_range(0, 9) == 0) w = k - 1;
                h = k + $urandom_range(0, 3);
            end
            style = $urandom_range(0, 2);
            for (int t = 0; t < 4; t++) cf[t] = rand_coef(style);
            program_plane(w, h, kf, cf);
            run_plane(w, h, ($urandom_range(0, 9) == 0), sent);
            plane++;
        end

        s_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (err_cnt == 0)
            $display("separable_convolution_2d_unit verification clean");
        else
            $display("separable_convolution_2d_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
